// ----- hw/rtl/cmq_pkg.sv -----
// Package for the coalescing message queue.
// Holds the entry and result layouts, the operation and kind codes, and the
// default depth. No dependencies.
package cmq_pkg;

	localparam int QUEUE_DEPTH_DEF = 128;

	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_POP  = 1'b1;

	localparam logic [1:0] KIND_CREATE = 2'd0;
	localparam logic [1:0] KIND_DIRTY  = 2'd1;
	localparam logic [1:0] KIND_CLOSE  = 2'd2;
	localparam logic [1:0] KIND_NONE   = 2'd3;

	localparam int S_TDATA_W = 136;
	localparam int S_TUSER_W = 3;
	localparam int M_TDATA_W = 136;

	// kind in the lowest bits, flags in the highest
	typedef struct packed {
		logic [31:0] flags;
		logic [15:0] height;
		logic [15:0] width;
		logic [31:0] win_id;
		logic [31:0] owner;
		logic [1:0]  kind;
	} cmq_entry_t;

	typedef struct packed {
		cmq_entry_t msg;
		logic       dropped;
		logic       coalesced;
		logic       ok;
	} cmq_result_t;

endpackage

// ----- hw/rtl/cmq_ram.sv -----
// Generic single-clock RAM for the message queue.
// One write port, one read port with registered read data. No dependencies.
module cmq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hw/rtl/coalescing_message_queue.sv -----
// Top level of the coalescing window-message queue.
// Uses cmq_pkg and one cmq_ram instance holding the ring entries.
//
// Usage:
//   s_* channel carries one operation per item: push a message or pop the
//   oldest one. s_tuser selects the operation and the message kind.
//   m_* channel returns exactly one result item per accepted input item.
//   s_tready is high only while the block is idle; one item is in work at a
//   time and its result sits in an output register until m_tready takes it.
// Scan and handshake:
//   dirty push: the scan walks the queued entries from the oldest; it
//   reads one RAM entry per cycle over the single read port and compares
//   it in the next cycle.
//   s_tready returns in the cycle right after the result handshake.
// Reset clears both ring pointers, so the queue starts empty; RAM contents
//   are not cleared and never read before being written.
// A stalled receiver holds the result and blocks further input.
module coalescing_message_queue
	import cmq_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// owner_id, win_id, win_width, win_height, win_flags, caller_is_server, zero pad
	input  logic [S_TDATA_W-1:0] s_tdata,
	// func, kind
	input  logic [S_TUSER_W-1:0] s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// ok, was_coalesced, dropped_oldest, out_kind, out_owner, out_win_id,
	// msg_width, msg_height, out_flags, zero pad
	output logic [M_TDATA_W-1:0] m_tdata
);

	localparam int IDX_W   = $clog2(QUEUE_DEPTH);
	localparam int ENTRY_W = $bits(cmq_entry_t);
	localparam int RES_W   = $bits(cmq_result_t);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_EXEC   = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_APPEND = 3'd3;
	localparam logic [2:0] ST_POP    = 3'd4;
	localparam logic [2:0] ST_OUT    = 3'd5;

	function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
		ring_next = (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	logic [2:0]       state_q;
	logic [IDX_W-1:0] wr_q, rd_q, scan_q, pend_addr_q;
	logic             pend_q;
	logic             func_q, server_q;
	cmq_entry_t       msg_q;
	cmq_result_t      res_q;

	logic             ram_we, ram_re;
	logic [IDX_W-1:0] ram_waddr, ram_raddr;
	cmq_entry_t       ram_rdata;
	logic             scan_hit, pop_ok;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata  = {(M_TDATA_W - RES_W)'(0), res_q};

	assign scan_hit = pend_q && (ram_rdata.kind == KIND_DIRTY) &&
		(ram_rdata.win_id == msg_q.win_id);
	assign pop_ok   = server_q && (rd_q != wr_q);

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = rd_q;
		ram_we    = 1'b0;
		ram_waddr = wr_q;
		case (state_q)
			ST_EXEC: begin
				ram_re = (func_q == FUNC_POP) && pop_ok;
			end
			ST_SCAN: begin
				ram_raddr = scan_q;
				ram_re    = !scan_hit && (scan_q != wr_q);
				ram_we    = scan_hit;
				ram_waddr = pend_addr_q;
			end
			ST_APPEND: begin
				ram_we = 1'b1;
			end
			default: begin
				ram_re = 1'b0;
			end
		endcase
	end

	cmq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(msg_q),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				func_q       <= s_tuser[0];
				msg_q.kind   <= s_tuser[2:1];
				msg_q.owner  <= s_tdata[31:0];
				msg_q.win_id <= s_tdata[63:32];
				msg_q.width  <= s_tdata[79:64];
				msg_q.height <= s_tdata[95:80];
				msg_q.flags  <= s_tdata[127:96];
				server_q     <= s_tdata[128];
			end
			ST_EXEC: begin
				res_q <= '0;
				scan_q <= rd_q;
			end
			ST_SCAN: begin
				if (scan_hit) begin
					res_q.ok        <= 1'b1;
					res_q.coalesced <= 1'b1;
				end else if (scan_q != wr_q) begin
					pend_addr_q <= scan_q;
					scan_q      <= ring_next(scan_q);
				end
			end
			ST_APPEND: begin
				res_q.ok      <= 1'b1;
				res_q.dropped <= (ring_next(wr_q) == rd_q);
			end
			ST_POP: begin
				res_q.ok  <= 1'b1;
				res_q.msg <= ram_rdata;
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wr_q    <= '0;
			rd_q    <= '0;
			pend_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					pend_q <= 1'b0;
					if (func_q == FUNC_POP) begin
						state_q <= pop_ok ? ST_POP : ST_OUT;
					end else if (msg_q.kind == KIND_NONE) begin
						state_q <= ST_OUT;
					end else if (msg_q.kind == KIND_CREATE && (msg_q.owner == '0 ||
							msg_q.width == '0 || msg_q.height == '0)) begin
						state_q <= ST_OUT;
					end else if (msg_q.kind == KIND_DIRTY) begin
						state_q <= ST_SCAN;
					end else begin
						state_q <= ST_APPEND;
					end
				end
				ST_SCAN: begin
					if (scan_hit) begin
						state_q <= ST_OUT;
					end else if (scan_q != wr_q) begin
						pend_q <= 1'b1;
					end else begin
						state_q <= ST_APPEND;
					end
				end
				ST_APPEND: begin
					if (ring_next(wr_q) == rd_q) begin
						rd_q <= ring_next(rd_q);
					end
					wr_q    <= ring_next(wr_q);
					state_q <= ST_OUT;
				end
				ST_POP: begin
					rd_q    <= ring_next(rd_q);
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
